>>> rtl/ufe_pkg.sv
// shared constants, types and unit opcodes for the union-find engine
package ufe_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int IDX_W     = 10;
  localparam int LINK_W    = 12;

  // entry value of a root alone in its set
  localparam logic [LINK_W-1:0] LINK_SINGLE = '1;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [LINK_W-1:0] link_t;

  typedef enum logic [1:0] {
    OP_EQ,
    OP_GT,
    OP_ADD
  } op_e;

  typedef struct packed {
    op_e   op;
    link_t x;
    link_t y;
  } alu_req_t;

endpackage

>>> rtl/union_find_engine.sv
// union-find engine: sequencer over the link table, shared alu and result register
//
//  channel | dir | valid / stall            | payload
//  --------+-----+--------------------------+----------------------------
//  in      | in  | in_valid_i / in_stall_o  | mode_i, node_a_i, node_b_i
//  out     | out | out_valid_o / out_stall_i| connected_o
//
// after reset the link table is swept to -1, one entry a cycle, with
// in_stall_o high. an item is then taken in idle, then per node the root is
// walked and the path to it compressed, all through the one read port of
// the link table, then the two roots are compared; a join of two sets goes
// on through order, merge and link, and the result is then loaded.
// a waiting result holds while the next item is taken; a later result waits
// in its last state until out frees.
module union_find_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [ufe_pkg::IDX_W-1:0]    node_a_i,
  input  logic [ufe_pkg::IDX_W-1:0]    node_b_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         connected_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_SAME,
    S_ORDER,
    S_MERGE,
    S_LINK,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  ufe_pkg::addr_t clr_q, clr_d;
  logic mode_q, mode_d;
  ufe_pkg::addr_t node_a_q, node_a_d, node_b_q, node_b_d;
  logic side_q, side_d;
  ufe_pkg::addr_t cur_q, cur_d, walk_q, walk_d;
  ufe_pkg::addr_t root_a_q, root_a_d, root_b_q, root_b_d;
  ufe_pkg::link_t val_a_q, val_a_d, val_b_q, val_b_d;
  logic swap_q, swap_d;
  logic conn_q, conn_d;
  logic out_valid_q, out_valid_d;
  logic connected_q, connected_d;

  logic                        ram_we;
  ufe_pkg::addr_t              ram_waddr;
  logic [ufe_pkg::LINK_W-1:0]  ram_wdata;
  ufe_pkg::addr_t              ram_raddr;
  logic [ufe_pkg::LINK_W-1:0]  ram_rdata;

  ufe_pkg::alu_req_t           alu_req;
  logic [ufe_pkg::LINK_W-1:0]  alu_res;

  ufe_pkg::addr_t root_cur, win, lose;
  logic in_acc, in_range;

  ufe_ram #(
    .WIDTH(ufe_pkg::LINK_W),
    .DEPTH(ufe_pkg::MAX_NODES)
  ) u_link (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ufe_alu u_alu (
    .req_i(alu_req),
    .res_o(alu_res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_range    = (32'(node_a_i) < ufe_pkg::MAX_NODES) &&
                       (32'(node_b_i) < ufe_pkg::MAX_NODES);
  assign root_cur    = side_q ? root_b_q : root_a_q;
  assign win         = swap_q ? root_b_q : root_a_q;
  assign lose        = swap_q ? root_a_q : root_b_q;
  assign out_valid_o = out_valid_q;
  assign connected_o = connected_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    node_a_d    = node_a_q;
    node_b_d    = node_b_q;
    side_d      = side_q;
    cur_d       = cur_q;
    walk_d      = walk_q;
    root_a_d    = root_a_q;
    root_b_d    = root_b_q;
    val_a_d     = val_a_q;
    val_b_d     = val_b_q;
    swap_d      = swap_q;
    conn_d      = conn_q;
    out_valid_d = out_valid_q && out_stall_i;
    connected_d = connected_q;

    ram_we    = 1'b0;
    ram_waddr = walk_q;
    ram_wdata = ufe_pkg::LINK_W'(root_cur);
    ram_raddr = cur_q;

    alu_req.op = ufe_pkg::OP_EQ;
    alu_req.x  = ufe_pkg::link_t'(ufe_pkg::LINK_W'(walk_q));
    alu_req.y  = ufe_pkg::link_t'(ufe_pkg::LINK_W'(root_cur));

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = ufe_pkg::LINK_SINGLE;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ufe_pkg::ADDR_W'(ufe_pkg::MAX_NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_d    = mode_i;
          node_a_d  = ufe_pkg::ADDR_W'(node_a_i);
          node_b_d  = ufe_pkg::ADDR_W'(node_b_i);
          side_d    = 1'b0;
          cur_d     = ufe_pkg::ADDR_W'(node_a_i);
          ram_raddr = ufe_pkg::ADDR_W'(node_a_i);
          if (in_range) begin
            state_d = S_FIND;
          end else begin
            conn_d  = 1'b0;
            state_d = S_RESULT;
          end
        end
      end
      S_FIND: begin
        // read data is the entry of cur_q
        if (!ram_rdata[ufe_pkg::LINK_W-1]) begin
          cur_d     = ufe_pkg::ADDR_W'(ram_rdata);
          ram_raddr = ufe_pkg::ADDR_W'(ram_rdata);
        end else begin
          if (side_q) begin
            root_b_d = cur_q;
            val_b_d  = ufe_pkg::link_t'(ram_rdata);
            walk_d   = node_b_q;
          end else begin
            root_a_d = cur_q;
            val_a_d  = ufe_pkg::link_t'(ram_rdata);
            walk_d   = node_a_q;
          end
          ram_raddr = walk_d;
          state_d   = S_COMP;
        end
      end
      S_COMP: begin
        // point each node on the path straight at the root
        if (alu_res[0]) begin
          if (side_q) begin
            state_d = S_SAME;
          end else begin
            side_d    = 1'b1;
            cur_d     = node_b_q;
            ram_raddr = node_b_q;
            state_d   = S_FIND;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = walk_q;
          ram_wdata = ufe_pkg::LINK_W'(root_cur);
          walk_d    = ufe_pkg::ADDR_W'(ram_rdata);
          ram_raddr = ufe_pkg::ADDR_W'(ram_rdata);
        end
      end
      S_SAME: begin
        alu_req.x = ufe_pkg::link_t'(ufe_pkg::LINK_W'(root_a_q));
        alu_req.y = ufe_pkg::link_t'(ufe_pkg::LINK_W'(root_b_q));
        conn_d    = alu_res[0];
        if (alu_res[0] || mode_q) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_ORDER;
        end
      end
      S_ORDER: begin
        // more negative entry holds the larger set; ties keep root of a
        alu_req.op = ufe_pkg::OP_GT;
        alu_req.x  = val_a_q;
        alu_req.y  = val_b_q;
        swap_d     = alu_res[0];
        state_d    = S_MERGE;
      end
      S_MERGE: begin
        alu_req.op = ufe_pkg::OP_ADD;
        alu_req.x  = val_a_q;
        alu_req.y  = val_b_q;
        ram_we     = 1'b1;
        ram_waddr  = win;
        ram_wdata  = alu_res;
        state_d    = S_LINK;
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = lose;
        ram_wdata = ufe_pkg::LINK_W'(win);
        state_d   = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          connected_d = conn_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mode_q      <= 1'b0;
      node_a_q    <= '0;
      node_b_q    <= '0;
      side_q      <= 1'b0;
      cur_q       <= '0;
      walk_q      <= '0;
      root_a_q    <= '0;
      root_b_q    <= '0;
      val_a_q     <= '0;
      val_b_q     <= '0;
      swap_q      <= 1'b0;
      conn_q      <= 1'b0;
      out_valid_q <= 1'b0;
      connected_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mode_q      <= mode_d;
      node_a_q    <= node_a_d;
      node_b_q    <= node_b_d;
      side_q      <= side_d;
      cur_q       <= cur_d;
      walk_q      <= walk_d;
      root_a_q    <= root_a_d;
      root_b_q    <= root_b_d;
      val_a_q     <= val_a_d;
      val_b_q     <= val_b_d;
      swap_q      <= swap_d;
      conn_q      <= conn_d;
      out_valid_q <= out_valid_d;
      connected_q <= connected_d;
    end
  end

  // a compression write never lands on the entry being read
  a_comp_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("compression write collides with read address");

  // a query never reaches the merge step
  a_query_no_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> !mode_q)
    else $error("query item reached merge");

  // a new result appears only out of the result state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESULT))
    else $error("result raised outside result state");

  // the link table is left alone while waiting for an item
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("link table written while idle");

endmodule

>>> rtl/ufe_ram.sv
// generic single-write, single-read ram with registered read data
module ufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ufe_alu.sv
// shared compare and add unit used by the sequencer
module ufe_alu (
  input  ufe_pkg::alu_req_t      req_i,
  output logic [ufe_pkg::LINK_W-1:0] res_o
);

  always_comb begin
    case (req_i.op)
      ufe_pkg::OP_EQ:  res_o = ufe_pkg::LINK_W'(req_i.x == req_i.y);
      ufe_pkg::OP_GT:  res_o = ufe_pkg::LINK_W'(req_i.x > req_i.y);
      ufe_pkg::OP_ADD: res_o = req_i.x + req_i.y;
      default:         res_o = '0;
    endcase
  end

endmodule
